// ===== design/cvc_pkg.sv =====
// Shared types and constants of the clamped-edge convolution block.
// No dependencies; imported by the convolution top level.
package cvc_pkg;

    // Input item commands
    typedef enum logic [1:0] {
        CMD_LOAD_COEF = 2'd0,
        CMD_WRITE_PIX = 2'd1,
        CMD_QUERY     = 2'd2
    } t_cmd;

    // Configuration register indexes
    localparam logic [1:0] REG_IMAGE_WIDTH    = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT   = 2'd1;
    localparam logic [1:0] REG_KERNEL_SIDE    = 2'd2;
    localparam logic [1:0] REG_NORMALIZE_MODE = 2'd3;

    localparam int CFG_W = 9;   // widest register
    localparam int CRD_W = 11;  // signed tap coordinate width

    typedef enum logic [2:0] {
        S_IDLE,
        S_ADDR,
        S_MAC,
        S_POST,
        S_DIV_START,
        S_DIV_WAIT,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]          cmd;
        logic [5:0]          coef_index;
        logic signed [15:0]  coef_value;
        logic [7:0]          pixel_x;
        logic [7:0]          pixel_y;
        logic [23:0]         pixel_value;
    } t_in_item;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       saturated;
        logic       divide_error;
    } t_out_item;

endpackage

// ===== design/clamped_edge_2d_convolution_top.sv =====
// Clamped-edge k-by-k RGB convolution: top level with sequencer and MAC unit.
// Depends on cvc_pkg, cvc_ram and cvc_div.
//
// Coefficient loads and pixel writes are written into their RAMs as they are
// accepted. A query walks the k*k window tap by tap: S_ADDR reads the frame
// and coefficient RAMs, then in S_MAC the single 9x16 multiplier serves red,
// green and blue in turn. Shift mode then passes S_POST and S_FIN; normalize
// mode runs the shared bit-serial divider once per channel between them.
// The input is not ready while a query is in flight; a finished result waits
// in the output register and the next item is taken while it waits. Taps
// clamp to the active image; reading a pixel or coefficient that was never
// written gives an undefined result.
module clamped_edge_2d_convolution_top
    import cvc_pkg::*;
#(
    parameter int MAX_WIDTH       = 256,
    parameter int MAX_HEIGHT      = 256,
    parameter int MAX_KERNEL_SIDE = 7
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  t_in_item         i_in_item,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output t_out_item        o_out_item,
    input  logic             i_cfg_we,
    input  logic [1:0]       i_cfg_idx,
    input  logic [CFG_W-1:0] i_cfg_data
);
    localparam int K2     = MAX_KERNEL_SIDE * MAX_KERNEL_SIDE;
    localparam int CIW    = (K2 > 1) ? $clog2(K2) : 1;
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int FAW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KW     = $clog2(MAX_KERNEL_SIDE + 1);
    localparam int SUMW   = $clog2(K2 + 1);
    localparam int ACC_W  = 25 + SUMW;
    localparam int CS_W   = 16 + SUMW;
    localparam int W_RST  = (MAX_WIDTH < 256) ? MAX_WIDTH : 256;
    localparam int H_RST  = (MAX_HEIGHT < 256) ? MAX_HEIGHT : 256;
    localparam int K_RST  = (MAX_KERNEL_SIDE < 3) ? MAX_KERNEL_SIDE : 3;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_img_w, r_img_h;
    logic [2:0]       r_k;
    logic             r_norm;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_img_w <= CFG_W'(W_RST);
            r_img_h <= CFG_W'(H_RST);
            r_k     <= 3'(K_RST);
            r_norm  <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_IMAGE_WIDTH: begin
                    if (i_cfg_data == '0)                      r_img_w <= CFG_W'(1);
                    else if (32'(i_cfg_data) > MAX_WIDTH)      r_img_w <= CFG_W'(MAX_WIDTH);
                    else                                       r_img_w <= i_cfg_data;
                end
                REG_IMAGE_HEIGHT: begin
                    if (i_cfg_data == '0)                      r_img_h <= CFG_W'(1);
                    else if (32'(i_cfg_data) > MAX_HEIGHT)     r_img_h <= CFG_W'(MAX_HEIGHT);
                    else                                       r_img_h <= i_cfg_data;
                end
                REG_KERNEL_SIDE: begin
                    if (i_cfg_data[2:0] == '0)                 r_k <= 3'd1;
                    else if (32'(i_cfg_data[2:0]) > MAX_KERNEL_SIDE)
                                                               r_k <= 3'(MAX_KERNEL_SIDE);
                    else                                       r_k <= i_cfg_data[2:0];
                end
                REG_NORMALIZE_MODE: r_norm <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------- sequencer state ----------------
    t_state               r_state, n_state;
    logic [KW-1:0]        r_r, n_r, r_c, n_c;
    logic [CIW-1:0]       r_ci, n_ci;
    logic [1:0]           r_ch, n_ch;
    logic [7:0]           r_px, n_px, r_py, n_py;
    logic signed [ACC_W-1:0] r_acc [3];
    logic signed [ACC_W-1:0] n_acc [3];
    logic signed [CS_W-1:0]  r_csum, n_csum;
    logic [7:0]           r_res [3];
    logic [7:0]           n_res [3];
    logic                 r_sat, n_sat, r_derr, n_derr;
    logic                 r_out_valid, n_out_valid;
    t_out_item            r_out, n_out;

    logic                 w_accept;
    logic [23:0]          w_pix_q;
    logic [15:0]          w_coef_q;
    logic signed [15:0]   w_coef;
    logic [7:0]           w_byte;
    logic signed [24:0]   w_prod;
    logic [KW-1:0]        w_half;
    logic signed [CRD_W-1:0] w_tx, w_ty;
    logic [CFG_W-1:0]     w_xx, w_yy;
    logic [31:0]          w_faddr;
    logic [31:0]          w_waddr;
    logic                 w_div_start, w_div_done;
    logic [ACC_W-1:0]     w_div_dvd, w_div_quo;
    logic [CS_W-1:0]      w_div_dvs;
    logic                 w_neg;
    logic [8:0]           w_sat_v;

    function automatic logic [8:0] f_sat(input logic signed [ACC_W:0] v);
        logic [8:0] res;
        if (v < 0)        res = {1'b1, 8'h00};
        else if (v > 255) res = {1'b1, 8'hFF};
        else              res = {1'b0, v[7:0]};
        return res;
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    // tap coordinates, clamped into the active image
    assign w_half = KW'(r_k >> 1);
    always_comb begin
        w_tx = signed'(CRD_W'(r_px)) - signed'(CRD_W'(w_half)) + signed'(CRD_W'(r_c));
        w_ty = signed'(CRD_W'(r_py)) - signed'(CRD_W'(w_half)) + signed'(CRD_W'(r_r));
        if (w_tx < 0)                               w_xx = '0;
        else if (w_tx >= signed'(CRD_W'(r_img_w)))  w_xx = r_img_w - 1'b1;
        else                                        w_xx = w_tx[CFG_W-1:0];
        if (w_ty < 0)                               w_yy = '0;
        else if (w_ty >= signed'(CRD_W'(r_img_h)))  w_yy = r_img_h - 1'b1;
        else                                        w_yy = w_ty[CFG_W-1:0];
    end
    assign w_faddr = 32'(w_yy) * 32'(MAX_WIDTH) + 32'(w_xx);
    assign w_waddr = 32'(i_in_item.pixel_y) * 32'(MAX_WIDTH) + 32'(i_in_item.pixel_x);

    cvc_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_frame_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in_item.cmd == CMD_WRITE_PIX
                  && 32'(i_in_item.pixel_x) < MAX_WIDTH
                  && 32'(i_in_item.pixel_y) < MAX_HEIGHT),
        .i_waddr (w_waddr[FAW-1:0]),
        .i_wdata (i_in_item.pixel_value),
        .i_raddr (w_faddr[FAW-1:0]),
        .o_rdata (w_pix_q)
    );

    cvc_ram #(.WIDTH(16), .DEPTH(K2)) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_accept && i_in_item.cmd == CMD_LOAD_COEF
                  && 32'(i_in_item.coef_index) < K2),
        .i_waddr (CIW'(i_in_item.coef_index)),
        .i_wdata (i_in_item.coef_value),
        .i_raddr (r_ci),
        .o_rdata (w_coef_q)
    );

    // one multiplier, one channel per cycle in S_MAC
    assign w_coef = signed'(w_coef_q);
    always_comb begin
        case (r_ch)
            2'd0:    w_byte = w_pix_q[23:16];
            2'd1:    w_byte = w_pix_q[15:8];
            default: w_byte = w_pix_q[7:0];
        endcase
    end
    assign w_prod = signed'({1'b0, w_byte}) * w_coef;

    // divider operands: magnitudes, sign applied afterward
    assign w_div_dvd = r_acc[r_ch][ACC_W-1] ? ACC_W'(-r_acc[r_ch]) : ACC_W'(r_acc[r_ch]);
    assign w_div_dvs = r_csum[CS_W-1] ? CS_W'(-r_csum) : CS_W'(r_csum);
    assign w_neg     = r_acc[r_ch][ACC_W-1] ^ r_csum[CS_W-1];
    assign w_sat_v   = f_sat(w_neg ? -signed'({1'b0, w_div_quo}) : signed'({1'b0, w_div_quo}));

    cvc_div #(.DVD_W(ACC_W), .DVS_W(CS_W)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    always_comb begin
        logic [8:0] s0, s1, s2;
        n_state     = r_state;
        n_r         = r_r;
        n_c         = r_c;
        n_ci        = r_ci;
        n_ch        = r_ch;
        n_px        = r_px;
        n_py        = r_py;
        n_acc       = r_acc;
        n_csum      = r_csum;
        n_res       = r_res;
        n_sat       = r_sat;
        n_derr      = r_derr;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_out_ready;
        w_div_start = 1'b0;
        s0 = f_sat(signed'((ACC_W+1)'(r_acc[0] >>> 8)));
        s1 = f_sat(signed'((ACC_W+1)'(r_acc[1] >>> 8)));
        s2 = f_sat(signed'((ACC_W+1)'(r_acc[2] >>> 8)));
        case (r_state)
            S_IDLE: begin
                if (w_accept && i_in_item.cmd == CMD_QUERY) begin
                    n_px    = i_in_item.pixel_x;
                    n_py    = i_in_item.pixel_y;
                    n_r     = '0;
                    n_c     = '0;
                    n_ci    = '0;
                    n_acc   = '{default: '0};
                    n_csum  = '0;
                    n_state = S_ADDR;
                end
            end
            S_ADDR: begin
                n_ch    = 2'd0;
                n_state = S_MAC;
            end
            S_MAC: begin
                n_acc[r_ch] = r_acc[r_ch] + ACC_W'(w_prod);
                if (r_ch == 2'd0) begin
                    n_csum = r_csum + CS_W'(w_coef);
                end
                if (r_ch != 2'd2) begin
                    n_ch = r_ch + 1'b1;
                end else begin
                    n_ci    = r_ci + 1'b1;
                    n_state = S_ADDR;
                    if (32'(r_c) == 32'(r_k) - 1) begin
                        n_c = '0;
                        if (32'(r_r) == 32'(r_k) - 1) begin
                            n_state = S_POST;
                        end else begin
                            n_r = r_r + 1'b1;
                        end
                    end else begin
                        n_c = r_c + 1'b1;
                    end
                end
            end
            S_POST: begin
                n_derr = 1'b0;
                n_sat  = 1'b0;
                if (!r_norm) begin
                    n_res[0] = s0[7:0];
                    n_res[1] = s1[7:0];
                    n_res[2] = s2[7:0];
                    n_sat    = s0[8] | s1[8] | s2[8];
                    n_state  = S_FIN;
                end else if (r_csum == '0) begin
                    n_res   = '{default: '0};
                    n_derr  = 1'b1;
                    n_state = S_FIN;
                end else begin
                    n_ch    = 2'd0;
                    n_state = S_DIV_START;
                end
            end
            S_DIV_START: begin
                w_div_start = 1'b1;
                n_state     = S_DIV_WAIT;
            end
            S_DIV_WAIT: begin
                if (w_div_done) begin
                    n_res[r_ch] = w_sat_v[7:0];
                    n_sat       = r_sat | w_sat_v[8];
                    if (r_ch == 2'd2) begin
                        n_state = S_FIN;
                    end else begin
                        n_ch    = r_ch + 1'b1;
                        n_state = S_DIV_START;
                    end
                end
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out.out_red      = r_res[0];
                    n_out.out_green    = r_res[1];
                    n_out.out_blue     = r_res[2];
                    n_out.saturated    = r_sat;
                    n_out.divide_error = r_derr;
                    n_out_valid        = 1'b1;
                    n_state            = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_r    <= n_r;
        r_c    <= n_c;
        r_ci   <= n_ci;
        r_ch   <= n_ch;
        r_px   <= n_px;
        r_py   <= n_py;
        r_acc  <= n_acc;
        r_csum <= n_csum;
        r_res  <= n_res;
        r_sat  <= n_sat;
        r_derr <= n_derr;
        r_out  <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTHESIS
    // an accepted query keeps the input closed on the next cycle
    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_in_item.cmd == CMD_QUERY) |=> !o_in_ready)
        else $error("input ready right after a query");

    // divide error only in normalize mode, and then with cleared channels
    a_derr_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.divide_error) |-> r_norm)
        else $error("divide error outside normalize mode");

    a_derr_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.divide_error) |->
        (o_out_item.out_red == 8'd0 && o_out_item.out_green == 8'd0 &&
         o_out_item.out_blue == 8'd0 && !o_out_item.saturated))
        else $error("divide error with nonzero channels");

    // channel select never leaves the three channels while the MAC or divider runs
    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAC || r_state == S_DIV_WAIT) |-> (r_ch != 2'd3))
        else $error("channel select out of range");
`endif
endmodule

// ===== design/cvc_ram.sv =====
// Generic simple dual-port RAM, one write port, one registered read port.
// No dependencies.
module cvc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// ===== design/cvc_div.sv =====
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on nothing; used by the convolution top level for normalize mode.
module cvc_div #(
    parameter int DVD_W = 32,
    parameter int DVS_W = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DVS_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DVD_W-1:0] o_quotient
);
    localparam int CNT_W = $clog2(DVD_W + 1);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [DVD_W-1:0] r_dvd, n_dvd;
    logic [DVS_W-1:0] r_rem, n_rem;
    logic [DVS_W-1:0] r_dvs, n_dvs;
    logic [DVS_W:0]   w_shift;
    logic [DVS_W:0]   w_diff;

    always_comb begin
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_dvd   = r_dvd;
        n_rem   = r_rem;
        n_dvs   = r_dvs;
        w_shift = {r_rem, r_dvd[DVD_W-1]};
        w_diff  = w_shift - {1'b0, r_dvs};
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = '0;
            n_dvd  = i_dividend;
            n_rem  = '0;
            n_dvs  = i_divisor;
        end else if (r_busy) begin
            // quotient bits shift in at the bottom as dividend bits leave the top
            if (!w_diff[DVS_W]) begin
                n_rem = w_diff[DVS_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DVS_W-1:0];
                n_dvd = {r_dvd[DVD_W-2:0], 1'b0};
            end
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(DVD_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cnt <= n_cnt;
        r_dvd <= n_dvd;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
    end

    assign o_done     = r_done;
    assign o_quotient = r_dvd;
endmodule
